>>> sv/pwlt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pwlt_pkg
// Shared types and constants for the page walk latency tracker.
// ----------------------------------------------------------------------------
package pwlt_pkg;

    localparam int DEF_TABLE_DEPTH = 16;
    localparam int DEF_CYCLE_BITS  = 48;

    localparam int FIELD_BITS   = 48;
    localparam int LAT_BITS     = 16;
    localparam int CTX_BITS     = 5;
    localparam int MERGE_BITS   = 16;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [LAT_BITS-1:0] RST_WALK_LATENCY  = 16'd100;
    localparam logic [CTX_BITS-1:0] RST_CONTEXT_COUNT = 5'd4;

    localparam logic [CFG_IDX_BITS-1:0] REG_WALK_LATENCY  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CONTEXT_COUNT = 2'd1;

    localparam logic ACT_WALK = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RT_RD,
        ST_RT_CHK,
        ST_SR_RD,
        ST_SR_CHK,
        ST_HIT,
        ST_WK_DEC,
        ST_WK_RD,
        ST_WK_CHK,
        ST_WK_ADD,
        ST_WK_STORE,
        ST_LK_RD,
        ST_LK_CHK,
        ST_LK_END,
        ST_DLY
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_READ,
        OP_POP,
        OP_NEXT,
        OP_PREV,
        OP_HIT,
        OP_SET_LIVE,
        OP_WK_ACC,
        OP_WK_NOW,
        OP_WK_ADD,
        OP_WK_STORE,
        OP_LK_HOR,
        OP_LK_ACC,
        OP_LK_STOP,
        OP_DELAY
    } dp_op_t;

    typedef struct packed {
        logic action;
        logic live_zero;
        logic idx_at_live;
        logic idx_zero;
        logic ready_lt_now;
        logic page_eq;
        logic wk_reached;
        logic lk_busy;
        logic out_busy;
    } dp_status_t;

endpackage : pwlt_pkg
`default_nettype wire

>>> sv/pwlt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pwlt_ctrl
// Sequencer: walks retire, search and scan phases one table entry at a time.
// ----------------------------------------------------------------------------
module pwlt_ctrl
    import pwlt_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire dp_status_t status,
    output dp_op_t          op
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op         = OP_NONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    op         = OP_LOAD;
                    state_next = ST_RT_RD;
                end
            end
            ST_RT_RD: begin
                if (status.live_zero) begin
                    state_next = ST_SR_RD;
                end else begin
                    op         = OP_READ;
                    state_next = ST_RT_CHK;
                end
            end
            ST_RT_CHK: begin
                if (status.ready_lt_now) begin
                    op         = OP_POP;
                    state_next = ST_RT_RD;
                end else begin
                    state_next = ST_SR_RD;
                end
            end
            ST_SR_RD: begin
                if (!status.idx_at_live) begin
                    op         = OP_READ;
                    state_next = ST_SR_CHK;
                end else if (status.action == ACT_WALK) begin
                    op         = OP_SET_LIVE;
                    state_next = ST_WK_DEC;
                end else begin
                    op         = OP_LK_HOR;
                    state_next = ST_LK_RD;
                end
            end
            ST_SR_CHK: begin
                if (status.page_eq) begin
                    state_next = ST_HIT;
                end else begin
                    op         = OP_NEXT;
                    state_next = ST_SR_RD;
                end
            end
            ST_HIT: begin
                op         = OP_HIT;
                state_next = ST_DLY;
            end
            ST_WK_DEC: begin
                if (status.idx_zero) begin
                    op         = OP_WK_NOW;
                    state_next = ST_WK_ADD;
                end else begin
                    op         = OP_PREV;
                    state_next = ST_WK_RD;
                end
            end
            ST_WK_RD: begin
                op         = OP_READ;
                state_next = ST_WK_CHK;
            end
            ST_WK_CHK: begin
                op         = OP_WK_ACC;
                state_next = status.wk_reached ? ST_WK_ADD : ST_WK_DEC;
            end
            ST_WK_ADD: begin
                op         = OP_WK_ADD;
                state_next = ST_WK_STORE;
            end
            ST_WK_STORE: begin
                op         = OP_WK_STORE;
                state_next = ST_DLY;
            end
            ST_LK_RD: begin
                if (status.idx_at_live) begin
                    state_next = ST_LK_END;
                end else begin
                    op         = OP_READ;
                    state_next = ST_LK_CHK;
                end
            end
            ST_LK_CHK: begin
                if (status.lk_busy) begin
                    op         = OP_LK_ACC;
                    state_next = ST_LK_RD;
                end else begin
                    state_next = ST_LK_END;
                end
            end
            ST_LK_END: begin
                op         = OP_LK_STOP;
                state_next = ST_DLY;
            end
            ST_DLY: begin
                // hold until the result register is free
                if (!status.out_busy) begin
                    op         = OP_DELAY;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule : pwlt_ctrl
`default_nettype wire

>>> sv/pwlt_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pwlt_dp
// Datapath: walk table memory, ring pointers, accumulators and result register.
// ----------------------------------------------------------------------------
module pwlt_dp
    import pwlt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int CYCLE_BITS  = DEF_CYCLE_BITS
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire dp_op_t                  op,
    output dp_status_t                   status,
    input  wire logic                    in_action,
    input  wire logic [FIELD_BITS-1:0]   in_page,
    input  wire logic [FIELD_BITS-1:0]   in_now,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_idx,
    input  wire logic [31:0]             cfg_wdata,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [FIELD_BITS-1:0]        out_delay,
    output logic                         out_merged,
    output logic                         out_wait,
    output logic                         out_full
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = MERGE_BITS + 1 + IDX_W;
    localparam int CB    = CYCLE_BITS;
    localparam logic [IDX_W:0] DEPTH_V = (IDX_W+1)'(TABLE_DEPTH);
    localparam logic [MERGE_BITS-1:0] MERGE_MAX = '1;

    typedef logic [CB-1:0] cyc_t;

    logic [CB-1:0]         page_mem  [TABLE_DEPTH];
    logic [CB-1:0]         ready_mem [TABLE_DEPTH];
    logic [MERGE_BITS-1:0] merge_mem [TABLE_DEPTH];

    logic [LAT_BITS-1:0] lat_reg;
    logic [CTX_BITS-1:0] ctx_reg;
    logic [IDX_W-1:0]    oldest_reg;
    logic [IDX_W:0]      live_reg;
    logic [IDX_W:0]      idx_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                action_reg;
    cyc_t                page_reg, now_reg, tgt_reg, hor_reg;
    cyc_t                rd_page_reg, rd_ready_reg;
    logic [MERGE_BITS-1:0] rd_merge_reg;
    logic                out_valid_reg;
    logic [FIELD_BITS-1:0] delay_reg;
    logic                merged_reg, wait_reg, full_reg;

    logic [CB+FIELD_BITS-1:0] page_ext, now_ext;
    logic [IDX_W:0]  rd_sum, wr_sum;
    logic [IDX_W-1:0] rd_slot, wr_slot, oldest_inc;
    logic [CTX_BITS-1:0] ctx_eff;
    logic [CNT_W-1:0] cnt_add;
    logic [MERGE_BITS-1:0] merge_inc;
    cyc_t sum_a, sum_b, sum_q, diff;
    logic [CB:0] sum_w;
    logic [CB+FIELD_BITS-1:0] diff_ext;
    logic [FIELD_BITS-1:0] delay_sat;

    assign page_ext = {{CB{1'b0}}, in_page};
    assign now_ext  = {{CB{1'b0}}, in_now};

    // ring slot of a table position
    always_comb begin
        rd_sum = {1'b0, oldest_reg} + idx_reg;
        if (rd_sum >= DEPTH_V) begin
            rd_sum = rd_sum - DEPTH_V;
        end
        rd_slot = rd_sum[IDX_W-1:0];
        wr_sum  = {1'b0, oldest_reg} + live_reg;
        if (wr_sum >= DEPTH_V) begin
            wr_sum = wr_sum - DEPTH_V;
        end
        wr_slot = wr_sum[IDX_W-1:0];
        oldest_inc = (oldest_reg == IDX_W'(TABLE_DEPTH - 1)) ? '0 : oldest_reg + 1'b1;
    end

    assign ctx_eff   = (ctx_reg == '0) ? CTX_BITS'(1) : ctx_reg;
    assign cnt_add   = cnt_reg + CNT_W'(rd_merge_reg) + CNT_W'(1);
    assign merge_inc = (rd_merge_reg == MERGE_MAX) ? rd_merge_reg : rd_merge_reg + 1'b1;

    // one shared saturating adder
    always_comb begin
        unique case (op)
            OP_HIT:    begin sum_a = rd_ready_reg; sum_b = CB'(merge_inc);    end
            OP_WK_ACC: begin sum_a = rd_ready_reg; sum_b = CB'(rd_merge_reg); end
            OP_WK_ADD: begin sum_a = tgt_reg;      sum_b = CB'(lat_reg);      end
            OP_LK_HOR: begin sum_a = now_reg;      sum_b = CB'(lat_reg);      end
            default:   begin sum_a = tgt_reg;      sum_b = '0;                end
        endcase
        sum_w = {1'b0, sum_a} + {1'b0, sum_b};
        sum_q = sum_w[CB] ? '1 : sum_w[CB-1:0];
    end

    always_comb begin
        diff      = tgt_reg - now_reg;
        diff_ext  = {{FIELD_BITS{1'b0}}, diff};
        if (tgt_reg <= now_reg) begin
            delay_sat = '0;
        end else if (|diff_ext[CB+FIELD_BITS-1:FIELD_BITS]) begin
            delay_sat = '1;
        end else begin
            delay_sat = diff_ext[FIELD_BITS-1:0];
        end
    end

    always_comb begin
        status.action       = action_reg;
        status.live_zero    = (live_reg == '0);
        status.idx_at_live  = (idx_reg == live_reg);
        status.idx_zero     = (idx_reg == '0);
        status.ready_lt_now = (rd_ready_reg < now_reg);
        status.page_eq      = (rd_page_reg == page_reg);
        status.wk_reached   = (cnt_add >= CNT_W'(ctx_eff));
        status.lk_busy      = (rd_ready_reg <= hor_reg) && (now_reg < rd_ready_reg);
        status.out_busy     = out_valid_reg && !out_ready;
    end

    always_ff @(posedge aclk) begin
        if (op == OP_READ) begin
            rd_page_reg  <= page_mem[rd_slot];
            rd_ready_reg <= ready_mem[rd_slot];
            rd_merge_reg <= merge_mem[rd_slot];
        end
        if (op == OP_HIT) begin
            merge_mem[rd_slot] <= merge_inc;
        end else if (op == OP_WK_STORE && live_reg != DEPTH_V) begin
            page_mem[wr_slot]  <= page_reg;
            ready_mem[wr_slot] <= tgt_reg;
            merge_mem[wr_slot] <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lat_reg       <= RST_WALK_LATENCY;
            ctx_reg       <= RST_CONTEXT_COUNT;
            oldest_reg    <= '0;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_idx == REG_WALK_LATENCY) begin
                    lat_reg <= cfg_wdata[LAT_BITS-1:0];
                end else if (cfg_idx == REG_CONTEXT_COUNT) begin
                    ctx_reg <= cfg_wdata[CTX_BITS-1:0];
                end
            end
            if (op == OP_DELAY) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && out_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (op)
                OP_POP: begin
                    oldest_reg <= oldest_inc;
                    live_reg   <= live_reg - 1'b1;
                end
                OP_WK_STORE: begin
                    if (live_reg != DEPTH_V) begin
                        live_reg <= live_reg + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (op)
            OP_LOAD: begin
                action_reg <= in_action;
                page_reg   <= page_ext[CB-1:0];
                now_reg    <= now_ext[CB-1:0];
                idx_reg    <= '0;
                cnt_reg    <= '0;
                merged_reg <= 1'b0;
                wait_reg   <= 1'b0;
                full_reg   <= 1'b0;
            end
            OP_NEXT:     idx_reg <= idx_reg + 1'b1;
            OP_PREV:     idx_reg <= idx_reg - 1'b1;
            OP_SET_LIVE: idx_reg <= live_reg;
            OP_HIT: begin
                tgt_reg    <= sum_q;
                merged_reg <= 1'b1;
            end
            OP_WK_ACC: begin
                cnt_reg <= cnt_add;
                if (status.wk_reached) begin
                    tgt_reg  <= sum_q;
                    wait_reg <= 1'b1;
                end
            end
            OP_WK_NOW: tgt_reg <= now_reg;
            OP_WK_ADD: tgt_reg <= sum_q;
            OP_WK_STORE: begin
                if (live_reg == DEPTH_V) begin
                    full_reg <= 1'b1;
                end
            end
            OP_LK_HOR: begin
                hor_reg <= sum_q;
                idx_reg <= '0;
                cnt_reg <= '0;
            end
            OP_LK_ACC: begin
                cnt_reg <= cnt_add;
                idx_reg <= idx_reg + 1'b1;
            end
            OP_LK_STOP: begin
                // the entry that ended the busy run is still in the read register
                if (cnt_reg >= CNT_W'(ctx_eff) && idx_reg != live_reg) begin
                    wait_reg <= 1'b1;
                    tgt_reg  <= rd_ready_reg;
                end else begin
                    tgt_reg  <= '0;
                end
            end
            OP_DELAY: begin
                delay_reg  <= delay_sat;
                out_merged <= merged_reg;
                out_wait   <= wait_reg;
                out_full   <= full_reg;
            end
            default: begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_delay = delay_reg;

endmodule : pwlt_dp
`default_nettype wire

>>> sv/page_walk_latency_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// page_walk_latency_tracker
// Timing model of a page-table walker with a bounded number of walk contexts.
//
//  channel  direction  payload
//  s_       in         tdata {now_cycle, page_address}, tuser action
//  m_       out        tdata delay_cycles, tuser {table_full, context_wait, merged}
//  cfg_     in         cfg_index, cfg_data (0 walk_latency, 1 context_count)
//
// A request retires finished entries and searches the table for its page; on a miss
// a walk scans back and a lookup scans forward, one entry at a time: the table
// memory read is registered.
// Synchronous active-low reset empties the table and loads register defaults.
// A request is taken while the previous result waits on m_tready; a stalled
// output holds the sequencer only at its final step.
// ----------------------------------------------------------------------------
module page_walk_latency_tracker
    import pwlt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int CYCLE_BITS  = DEF_CYCLE_BITS
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [95:0]             s_tdata,  // page_address, now_cycle
    input  wire logic                    s_tuser,  // action
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [47:0]                  m_tdata,  // delay_cycles
    output logic [2:0]                   m_tuser,  // merged, context_wait, table_full
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [31:0]             cfg_data
);

    dp_op_t     op;
    dp_status_t status;
    logic       merged, ctx_wait, full;

    assign cfg_ready = 1'b1;

    pwlt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .op       (op)
    );

    pwlt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .CYCLE_BITS  (CYCLE_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .op         (op),
        .status     (status),
        .in_action  (s_tuser),
        .in_page    (s_tdata[47:0]),
        .in_now     (s_tdata[95:48]),
        .cfg_we     (cfg_valid),
        .cfg_idx    (cfg_index),
        .cfg_wdata  (cfg_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_delay  (m_tdata),
        .out_merged (merged),
        .out_wait   (ctx_wait),
        .out_full   (full)
    );

    assign m_tuser = {full, ctx_wait, merged};

endmodule : page_walk_latency_tracker
`default_nettype wire

>>> tb/tb_page_walk_latency_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_page_walk_latency_tracker
// Self-checking bench for the page walk latency tracker: a walk table model
// predicts each response, random stalls on both streams, register changes
// between phases.
// ----------------------------------------------------------------------------
module tb_page_walk_latency_tracker;
    import pwlt_pkg::*;

    localparam int DEPTH = 16;
    localparam logic [63:0] CYC_MAX = 64'hFFFF_FFFF_FFFF;
    localparam int DRAIN_CYCLES = 6 * DEPTH + 40;

    typedef struct {
        logic [47:0] delay;
        logic        merged;
        logic        ctx_wait;
        logic        full;
    } walk_result_t;

    class latency_scoreboard;
        bit          slot_live [DEPTH];
        logic [47:0] slot_page [DEPTH];
        logic [63:0] slot_ready[DEPTH];
        int unsigned slot_merges[DEPTH];
        int unsigned head;
        int unsigned live;
        int unsigned walk_lat;
        int unsigned ctx_limit;
        walk_result_t pending_results[$];
        int unsigned mismatches;

        function new();
            head = 0;
            live = 0;
            walk_lat = RST_WALK_LATENCY;
            ctx_limit = RST_CONTEXT_COUNT;
            mismatches = 0;
            foreach (slot_live[i]) slot_live[i] = 0;
        endfunction

        function void report(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            mismatches++;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] data);
            if (idx == REG_WALK_LATENCY) walk_lat = data[15:0];
            else if (idx == REG_CONTEXT_COUNT) ctx_limit = data[4:0];
        endfunction

        function logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
            logic [63:0] r;
            r = a + b;
            return (r > CYC_MAX) ? CYC_MAX : r;
        endfunction

        function logic [47:0] cycles_until(logic [63:0] target, logic [63:0] now);
            return (target <= now) ? 48'd0 : 48'(target - now);
        endfunction

        function void note_request(logic act, logic [47:0] page, logic [47:0] now);
            int unsigned ctx, cnt, i, s;
            bit hit;
            logic [63:0] start, rdy, horizon;
            walk_result_t r;
            ctx = (ctx_limit == 0) ? 1 : ctx_limit;
            cnt = 0;
            hit = 0;
            r = '{48'd0, 1'b0, 1'b0, 1'b0};
            // retire finished walks, oldest first
            while (live > 0 && slot_ready[head] < now) begin
                slot_live[head] = 0;
                head = (head + 1) % DEPTH;
                live--;
            end
            for (i = 0; i < live; i++) begin
                s = (head + i) % DEPTH;
                if (slot_live[s] && slot_page[s] == page) begin
                    hit = 1;
                    break;
                end
            end
            if (hit) begin
                s = (head + i) % DEPTH;
                if (slot_merges[s] < 65535) slot_merges[s]++;
                r.delay = cycles_until(sat_add(slot_ready[s], slot_merges[s]), now);
                r.merged = 1;
            end else if (act == ACT_WALK) begin
                start = now;
                for (i = live; i > 0; i--) begin
                    s = (head + i - 1) % DEPTH;
                    cnt += slot_merges[s] + 1;
                    if (cnt >= ctx) begin
                        start = sat_add(slot_ready[s], slot_merges[s]);
                        r.ctx_wait = 1;
                        break;
                    end
                end
                rdy = sat_add(start, walk_lat);
                r.delay = cycles_until(rdy, now);
                if (live >= DEPTH) begin
                    r.full = 1;
                end else begin
                    s = (head + live) % DEPTH;
                    slot_live[s] = 1;
                    slot_page[s] = page;
                    slot_ready[s] = rdy;
                    slot_merges[s] = 0;
                    live++;
                end
            end else begin
                horizon = sat_add(now, walk_lat);
                for (i = 0; i < live; i++) begin
                    s = (head + i) % DEPTH;
                    if (slot_ready[s] <= horizon && now < slot_ready[s])
                        cnt += slot_merges[s] + 1;
                    else
                        break;
                end
                if (cnt >= ctx && i < live) begin
                    r.ctx_wait = 1;
                    r.delay = cycles_until(slot_ready[(head + i) % DEPTH], now);
                end
            end
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [47:0] delay, logic [2:0] flags);
            walk_result_t e;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected response delay=%0d flags=%b", delay, flags));
                return;
            end
            e = pending_results.pop_front();
            if (delay !== e.delay)
                report($sformatf("delay_cycles %0d, expected %0d", delay, e.delay));
            if (flags[0] !== e.merged)
                report($sformatf("merged %b, expected %b", flags[0], e.merged));
            if (flags[1] !== e.ctx_wait)
                report($sformatf("context_wait %b, expected %b", flags[1], e.ctx_wait));
            if (flags[2] !== e.full)
                report($sformatf("table_full %b, expected %b", flags[2], e.full));
        endfunction
    endclass

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [95:0]             s_tdata;   // page_address, now_cycle
    logic                    s_tuser;   // action
    logic                    m_tvalid;
    logic                    m_tready;
    logic [47:0]             m_tdata;   // delay_cycles
    logic [2:0]              m_tuser;   // merged, context_wait, table_full
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [31:0]             cfg_data;

    latency_scoreboard sb;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    logic [47:0] cur_now;
    logic [47:0] page_pool[8];

    page_walk_latency_tracker i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("page_walk_latency_tracker verification failed");
        $finish;
    end

    // receiver stalls
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end

    task automatic send_req(logic act, logic [47:0] page, logic [47:0] now);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_tvalid = 0;
        end
        @(negedge aclk);
        s_tvalid = 1;
        s_tuser = act;
        s_tdata = {now, page};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(act, page, now);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 0;
        while (sb.pending_results.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] data);
        @(negedge aclk);
        cfg_valid = 1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_valid = 0;
    endtask

    task automatic run_phase(int unsigned items, logic [15:0] lat, logic [4:0] ctx,
                             logic [47:0] base);
        logic [47:0] page;
        logic act;
        wait_drained();
        // upper data bits are don't-care
        write_reg(REG_WALK_LATENCY, {16'($urandom_range(65535)), lat});
        write_reg(REG_CONTEXT_COUNT, {27'($urandom), ctx});
        cur_now = base;
        foreach (page_pool[i]) page_pool[i] = 48'({$urandom, $urandom}) & 48'hFFFF_FFFF_F000;
        for (int n = 0; n < items; n++) begin
            page = ($urandom_range(9) < 7) ? page_pool[$urandom_range(7)]
                                           : 48'({$urandom, $urandom});
            act = ($urandom_range(99) < 30);
            case ($urandom_range(19))
                0: cur_now = cur_now - $urandom_range(20);
                1: cur_now = cur_now + $urandom_range(3 * lat + 100);
                default: cur_now = cur_now + $urandom_range(lat / 8 + 4);
            endcase
            if ($urandom_range(99) == 0) wait_drained();
            send_req(act, page, cur_now);
        end
    endtask

    initial begin
        sb = new();
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = 0;
        m_tready = 0;
        cfg_valid = 0;
        cfg_index = REG_WALK_LATENCY;
        cfg_data = '0;
        send_idle_pct = 29;
        recv_idle_pct = 45;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // directed: merge, lookups, extreme pages, full table, time going back
        send_req(ACT_WALK, 48'h0, 48'd0);
        send_req(ACT_WALK, 48'h0, 48'd1);
        send_req(!ACT_WALK, 48'h0, 48'd2);
        send_req(!ACT_WALK, 48'hFFFF_FFFF_FFFF, 48'd3);
        send_req(ACT_WALK, 48'hFFFF_FFFF_FFFF, 48'd3);
        send_req(ACT_WALK, 48'h1000, 48'd1);
        for (int k = 0; k < 16; k++) send_req(ACT_WALK, 48'h2000 + k, 48'd50);
        send_req(!ACT_WALK, 48'h9999, 48'd60);
        send_req(ACT_WALK, 48'h5555_5555_5555, 48'd60000);
        send_req(!ACT_WALK, 48'hAAAA_AAAA_AAAA, 48'd60000);

        run_phase(115, 16'd1, 5'd1, 48'd100000);
        run_phase(115, 16'd65535, 5'd16, 48'h5555_5555_0000);
        send_idle_pct = 45;
        recv_idle_pct = 29;
        run_phase(115, 16'd37, 5'd0, 48'hAAAA_AAAA_0000);
        run_phase(115, 16'd200, 5'd31, 48'h0F0F_0F0F_0000);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(115, 16'd100, 5'd4, 48'h7000_0000_0000);
        // cycle counts run into saturation here
        run_phase(115, 16'd65535, 5'd3, 48'hFFFF_FFFF_0000);

        wait_drained();
        if (sb.mismatches == 0) begin
            $display("page_walk_latency_tracker verification clean");
        end else begin
            $display("page_walk_latency_tracker verification failed");
        end
        $finish;
    end
endmodule
